### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the layer blend block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PLB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define PLB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// types and constants shared by the layer blend block
// ----------------------------------------------------------------------------
package plb_pkg;

   localparam int CHAN_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 8;
   localparam int MODE_WIDTH      = 3;

   // brightest channel value
   localparam logic [CHAN_WIDTH-1:0] CHAN_MAX = 8'd255;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_MULTIPLY = 3'd0,
      MODE_SUBTRACT = 3'd1,
      MODE_SCREEN   = 3'd2,
      MODE_OVERLAY  = 3'd3,
      MODE_ADD      = 3'd4,
      MODE_SCALE    = 3'd5
   } plb_mode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BLEND_MODE   = 2'd0,
      CSR_BLUE_AMOUNT  = 2'd1,
      CSR_GREEN_AMOUNT = 2'd2,
      CSR_RED_AMOUNT   = 2'd3
   } plb_csr_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] top_blue;
      logic [CHAN_WIDTH-1:0] top_green;
      logic [CHAN_WIDTH-1:0] top_red;
      logic [CHAN_WIDTH-1:0] bot_blue;
      logic [CHAN_WIDTH-1:0] bot_green;
      logic [CHAN_WIDTH-1:0] bot_red;
   } plb_req_type;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] out_blue;
      logic [CHAN_WIDTH-1:0] out_green;
      logic [CHAN_WIDTH-1:0] out_red;
   } plb_rsp_type;

   // per-channel settings handed to each channel pipe
   typedef struct packed {
      plb_mode_type          mode;
      logic [CHAN_WIDTH-1:0] amount;
   } plb_chan_cfg_type;

endpackage

### hdl/pixel_layer_blend.sv
// ----------------------------------------------------------------------------
// pixel_layer_blend
// blends a top and a bottom RGB pixel per channel in the configured mode
// ----------------------------------------------------------------------------
//  channel   ports                                  direction
//  request   start, busy, req_data                  in
//  response  rsp_valid, rsp_data                    out
//  control   csr_valid, csr_ready, csr_index,       in
//            csr_data
//
//  one pixel per clock; each result passes in turn through the four
//  register stages of the channel pipe (prep, multiply,
//  divide estimate, correction)
//  reset clears the stage valid bits and the control registers
//  busy stays low and the pipe never stalls; results go out on rsp_valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_layer_blend (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  plb_pkg::plb_req_type                  req_data,
   output logic                                  rsp_valid,
   output plb_pkg::plb_rsp_type                  rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [plb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [plb_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import plb_pkg::*;

   plb_mode_type          mode_ff;
   logic [CHAN_WIDTH-1:0] blue_amount_ff;
   logic [CHAN_WIDTH-1:0] green_amount_ff;
   logic [CHAN_WIDTH-1:0] red_amount_ff;

   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;

   logic accept;
   logic csr_write;

   plb_chan_cfg_type blue_cfg;
   plb_chan_cfg_type green_cfg;
   plb_chan_cfg_type red_cfg;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_MULTIPLY;
         blue_amount_ff  <= '0;
         green_amount_ff <= '0;
         red_amount_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BLEND_MODE:   mode_ff         <= plb_mode_type'(csr_data[MODE_WIDTH-1:0]);
            CSR_BLUE_AMOUNT:  blue_amount_ff  <= csr_data[CHAN_WIDTH-1:0];
            CSR_GREEN_AMOUNT: green_amount_ff <= csr_data[CHAN_WIDTH-1:0];
            CSR_RED_AMOUNT:   red_amount_ff   <= csr_data[CHAN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // valid bits follow the data through the stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // per-channel settings
   always_comb begin
      blue_cfg  = '{mode: mode_ff, amount: blue_amount_ff};
      green_cfg = '{mode: mode_ff, amount: green_amount_ff};
      red_cfg   = '{mode: mode_ff, amount: red_amount_ff};
   end

   plb_channel u_blue (
      .clock    (clock),
      .chan_cfg (blue_cfg),
      .top_chan (req_data.top_blue),
      .bot_chan (req_data.bot_blue),
      .res_chan (rsp_data.out_blue)
   );

   plb_channel u_green (
      .clock    (clock),
      .chan_cfg (green_cfg),
      .top_chan (req_data.top_green),
      .bot_chan (req_data.bot_green),
      .res_chan (rsp_data.out_green)
   );

   plb_channel u_red (
      .clock    (clock),
      .chan_cfg (red_cfg),
      .top_chan (req_data.top_red),
      .bot_chan (req_data.bot_red),
      .res_chan (rsp_data.out_red)
   );

   // every result comes from an earlier transfer
   `PLB_ASSERT_IMP(a_rsp_has_source, clock, reset, rsp_valid, $past(accept, 4))

   // a transfer not hit by reset always comes out as a result
   `PLB_ASSERT_IMP(a_transfer_delivered, clock, reset, $past(accept, 4) && !$past(reset, 4) && !$past(reset, 3) && !$past(reset, 2) && !$past(reset, 1), rsp_valid)

   // a mode write lands in the mode register
   `PLB_ASSERT_NXT(a_mode_write, clock, reset, csr_write && csr_index == CSR_BLEND_MODE, mode_ff == $past(csr_data[MODE_WIDTH-1:0]))

endmodule

### hdl/plb_channel.sv
// ----------------------------------------------------------------------------
// plb_channel
// four-stage datapath for one color channel: operand prep, multiply,
// divide-by-255 estimate, correction and result select
// ----------------------------------------------------------------------------
module plb_channel (
   input  logic                             clock,
   input  plb_pkg::plb_chan_cfg_type        chan_cfg,
   input  logic [plb_pkg::CHAN_WIDTH-1:0]   top_chan,
   input  logic [plb_pkg::CHAN_WIDTH-1:0]   bot_chan,
   output logic [plb_pkg::CHAN_WIDTH-1:0]   res_chan
);
   import plb_pkg::*;

   localparam int MUL_WIDTH  = 2 * CHAN_WIDTH;
   localparam int PROD_WIDTH = 2 * CHAN_WIDTH + 1;
   localparam int QUOT_WIDTH = CHAN_WIDTH + 1;
   localparam int REM_WIDTH  = CHAN_WIDTH + 2;

   // rounding bias and correction limits for round(p / 255)
   localparam logic [PROD_WIDTH-1:0] ROUND_BIAS = 17'd127;
   localparam logic [REM_WIDTH-1:0]  REM_ONE    = 10'd255;
   localparam logic [REM_WIDTH-1:0]  REM_TWO    = 10'd510;

   typedef enum logic [1:0] {
      KIND_DIV,
      KIND_SAT,
      KIND_DIRECT
   } kind_type;

   // stage 1 registers
   kind_type              s1_kind_ff,   s1_kind_in;
   logic [CHAN_WIDTH-1:0] s1_x_ff,      s1_x_in;
   logic [CHAN_WIDTH-1:0] s1_y_ff,      s1_y_in;
   logic                  s1_dbl_ff,    s1_dbl_in;
   logic                  s1_inv_ff,    s1_inv_in;
   logic [CHAN_WIDTH-1:0] s1_direct_ff, s1_direct_in;

   // stage 2 registers
   kind_type              s2_kind_ff;
   logic [PROD_WIDTH-1:0] s2_prod_ff,   s2_prod_in;
   logic                  s2_inv_ff;
   logic [CHAN_WIDTH-1:0] s2_direct_ff;

   // stage 3 registers
   kind_type              s3_kind_ff;
   logic [QUOT_WIDTH-1:0] s3_quot_ff,   s3_quot_in;
   logic [REM_WIDTH-1:0]  s3_rem_ff,    s3_rem_in;
   logic                  s3_over_ff,   s3_over_in;
   logic [CHAN_WIDTH-1:0] s3_low_ff;
   logic                  s3_inv_ff;
   logic [CHAN_WIDTH-1:0] s3_direct_ff;

   // stage 4 result
   logic [CHAN_WIDTH-1:0] res_ff,       res_in;

   logic [CHAN_WIDTH:0]   add_sum;
   logic [PROD_WIDTH-1:0] biased;
   logic [QUOT_WIDTH-1:0] quot_fix;
   logic [CHAN_WIDTH-1:0] div_res;
   logic [CHAN_WIDTH-1:0] sat_res;

   // operand prep: every mode maps onto one product, a clamp or a direct value
   always_comb begin
      add_sum      = {1'b0, top_chan} + {1'b0, chan_cfg.amount};
      s1_kind_in   = KIND_DIRECT;
      s1_x_in      = top_chan;
      s1_y_in      = bot_chan;
      s1_dbl_in    = 1'b0;
      s1_inv_in    = 1'b0;
      s1_direct_in = top_chan;
      case (chan_cfg.mode)
         MODE_MULTIPLY: begin
            s1_kind_in = KIND_DIV;
         end
         MODE_SUBTRACT: begin
            s1_direct_in = (bot_chan > top_chan) ? (bot_chan - top_chan) : '0;
         end
         MODE_SCREEN: begin
            s1_kind_in = KIND_DIV;
            s1_x_in    = ~top_chan;
            s1_y_in    = ~bot_chan;
            s1_inv_in  = 1'b1;
         end
         MODE_OVERLAY: begin
            s1_kind_in = KIND_DIV;
            s1_dbl_in  = 1'b1;
            // upper half of the bottom value takes the inverted screen form
            if (bot_chan[CHAN_WIDTH-1]) begin
               s1_x_in   = ~top_chan;
               s1_y_in   = ~bot_chan;
               s1_inv_in = 1'b1;
            end
         end
         MODE_ADD: begin
            s1_direct_in = add_sum[CHAN_WIDTH] ? CHAN_MAX : add_sum[CHAN_WIDTH-1:0];
         end
         MODE_SCALE: begin
            s1_kind_in = KIND_SAT;
            s1_y_in    = chan_cfg.amount;
         end
         default: begin
            s1_direct_in = top_chan;
         end
      endcase
   end

   // multiply, doubled for overlay
   always_comb begin
      s2_prod_in = {1'b0, MUL_WIDTH'(s1_x_ff) * MUL_WIDTH'(s1_y_ff)};
      if (s1_dbl_ff) begin
         s2_prod_in = {s2_prod_in[PROD_WIDTH-2:0], 1'b0};
      end
   end

   // divide by 255: quotient estimate from n / 256 and its remainder
   always_comb begin
      biased     = s2_prod_ff + ROUND_BIAS;
      s3_quot_in = biased[PROD_WIDTH-1:CHAN_WIDTH];
      s3_rem_in  = {2'b00, biased[CHAN_WIDTH-1:0]} + {1'b0, s3_quot_in};
      s3_over_in = |s2_prod_ff[PROD_WIDTH-1:CHAN_WIDTH];
   end

   // correct the estimate and pick the result for the mode
   always_comb begin
      quot_fix = s3_quot_ff;
      if (s3_rem_ff >= REM_TWO) begin
         quot_fix = s3_quot_ff + 9'd2;
      end else if (s3_rem_ff >= REM_ONE) begin
         quot_fix = s3_quot_ff + 9'd1;
      end
      div_res = s3_inv_ff ? ~quot_fix[CHAN_WIDTH-1:0] : quot_fix[CHAN_WIDTH-1:0];
      sat_res = s3_over_ff ? CHAN_MAX : s3_low_ff;
      case (s3_kind_ff)
         KIND_DIV: res_in = div_res;
         KIND_SAT: res_in = sat_res;
         default:  res_in = s3_direct_ff;
      endcase
   end

   // pipeline registers, payload only
   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      s1_dbl_ff    <= s1_dbl_in;
      s1_inv_ff    <= s1_inv_in;
      s1_direct_ff <= s1_direct_in;

      s2_kind_ff   <= s1_kind_ff;
      s2_prod_ff   <= s2_prod_in;
      s2_inv_ff    <= s1_inv_ff;
      s2_direct_ff <= s1_direct_ff;

      s3_kind_ff   <= s2_kind_ff;
      s3_quot_ff   <= s3_quot_in;
      s3_rem_ff    <= s3_rem_in;
      s3_over_ff   <= s3_over_in;
      s3_low_ff    <= s2_prod_ff[CHAN_WIDTH-1:0];
      s3_inv_ff    <= s2_inv_ff;
      s3_direct_ff <= s2_direct_ff;

      res_ff       <= res_in;
   end

   assign res_chan = res_ff;

endmodule

### tb/sv/tb_pixel_layer_blend.sv
// ----------------------------------------------------------------------------
// tb_pixel_layer_blend
// self-checking bench for the RGB layer blend block: a short directed pass
// walks every blend mode over edge-value pixels, then randomized phases each
// pick a mode and per-channel amounts (fixed in phases four and five) and
// stream random pixels, gapped except in phase six; a scoreboard computes
// every blended pixel and checks the output per channel, in transfer order
// ----------------------------------------------------------------------------
module tb_pixel_layer_blend;
   import plb_pkg::*;

   localparam int unsigned CHAN_FULL    = CHAN_MAX;
   localparam int unsigned OVERLAY_KNEE = 127;
   localparam int          CYCLE_LIMIT  = 100000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          IDLE_PERCENT = 33;
   localparam int          PHASE_COUNT  = 11;
   localparam int          PHASE_ITEMS  = 57;
   localparam int          JUNK_WIDTH   = CSR_DATA_WIDTH - MODE_WIDTH;

   // blended pixel predictor and in-order result store
   class blend_scoreboard;
      logic [MODE_WIDTH-1:0] mode;
      logic [CHAN_WIDTH-1:0] blue_amount;
      logic [CHAN_WIDTH-1:0] green_amount;
      logic [CHAN_WIDTH-1:0] red_amount;
      plb_rsp_type           expected_pixels[$];
      int                    mismatch_count;

      function new();
         mode           = MODE_MULTIPLY;
         blue_amount    = '0;
         green_amount   = '0;
         red_amount     = '0;
         mismatch_count = 0;
      endfunction

      // only the low bits of the mode register are kept
      function void write_register(logic [CSR_INDEX_WIDTH-1:0] index,
                                   logic [CSR_DATA_WIDTH-1:0] data);
         case (index)
            CSR_BLEND_MODE:   mode = data[MODE_WIDTH-1:0];
            CSR_BLUE_AMOUNT:  blue_amount = data;
            CSR_GREEN_AMOUNT: green_amount = data;
            CSR_RED_AMOUNT:   red_amount = data;
            default: ;
         endcase
      endfunction

      // round(n / 255), half up
      function int unsigned div255_round(int unsigned n);
         return (2 * n + CHAN_FULL) / (2 * CHAN_FULL);
      endfunction

      function logic [CHAN_WIDTH-1:0] blend_channel(int unsigned t, int unsigned b,
                                                    int unsigned amount);
         int unsigned r;
         case (mode)
            MODE_MULTIPLY: r = div255_round(t * b);
            MODE_SUBTRACT: r = (b > t) ? b - t : 0;
            MODE_SCREEN:   r = CHAN_FULL - div255_round((CHAN_FULL - t) * (CHAN_FULL - b));
            MODE_OVERLAY: begin
               if (b <= OVERLAY_KNEE)
                  r = div255_round(2 * t * b);
               else
                  r = CHAN_FULL - div255_round(2 * (CHAN_FULL - t) * (CHAN_FULL - b));
            end
            MODE_ADD:      r = (t + amount > CHAN_FULL) ? CHAN_FULL : t + amount;
            MODE_SCALE:    r = (t * amount > CHAN_FULL) ? CHAN_FULL : t * amount;
            // unused mode codes pass the top pixel through
            default:       r = t;
         endcase
         return r[CHAN_WIDTH-1:0];
      endfunction

      function void note_pixel(plb_req_type px);
         plb_rsp_type blended;
         blended.out_blue  = blend_channel(px.top_blue, px.bot_blue, blue_amount);
         blended.out_green = blend_channel(px.top_green, px.bot_green, green_amount);
         blended.out_red   = blend_channel(px.top_red, px.bot_red, red_amount);
         expected_pixels.push_back(blended);
      endfunction

      function void compare_channel(string name, logic [CHAN_WIDTH-1:0] want,
                                    logic [CHAN_WIDTH-1:0] got);
         if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_pixel(plb_rsp_type got);
         plb_rsp_type want;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
         end else begin
            want = expected_pixels.pop_front();
            compare_channel("out_blue", want.out_blue, got.out_blue);
            compare_channel("out_green", want.out_green, got.out_green);
            compare_channel("out_red", want.out_red, got.out_red);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       start     = 1'b0;
   logic                       busy;
   plb_req_type                req_data  = '0;
   logic                       rsp_valid;
   plb_rsp_type                rsp_data;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;
   int                         cycle_count = 0;
   blend_scoreboard            board = new();

   pixel_layer_blend DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // observe every transfer on the three channels
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_pixel(req_data);
         if (rsp_valid)
            board.check_pixel(rsp_data);
         if (csr_valid && csr_ready)
            board.write_register(csr_index, csr_data);
      end
   end

   // edge levels show up often, overlay knee included
   function automatic logic [CHAN_WIDTH-1:0] channel_level();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd127;
         3:       return 8'd128;
         default: return CHAN_WIDTH'($urandom_range(255));
      endcase
   endfunction

   function automatic plb_req_type random_pixel();
      plb_req_type px;
      px.top_blue  = channel_level();
      px.top_green = channel_level();
      px.top_red   = channel_level();
      px.bot_blue  = channel_level();
      px.bot_green = channel_level();
      px.bot_red   = channel_level();
      return px;
   endfunction

   function automatic logic [CHAN_WIDTH-1:0] random_amount();
      case ($urandom_range(3))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return CHAN_WIDTH'($urandom_range(1, 4));
         default: return CHAN_WIDTH'($urandom_range(255));
      endcase
   endfunction

   // one pixel transfer, with random idle cycles ahead of it when gaps are allowed
   task automatic send_pixel(input plb_req_type px, input bit allow_gaps);
      if (allow_gaps)
         while ($urandom_range(99) < IDLE_PERCENT) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start    <= 1'b1;
      req_data <= px;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // stop sending and let the pipe drain
   task automatic wait_idle();
      start <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register transfer; csr_valid stays up for a following write
   task automatic write_csr(input plb_csr_type index, input logic [CSR_DATA_WIDTH-1:0] data);
      while ($urandom_range(99) < IDLE_PERCENT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // upper mode bits carry junk that the block must drop
   task automatic apply_settings(input logic [MODE_WIDTH-1:0] mode,
                                 input logic [JUNK_WIDTH-1:0] junk,
                                 input logic [CHAN_WIDTH-1:0] blue,
                                 input logic [CHAN_WIDTH-1:0] green,
                                 input logic [CHAN_WIDTH-1:0] red);
      wait_idle();
      write_csr(CSR_BLEND_MODE, {junk, mode});
      write_csr(CSR_BLUE_AMOUNT, blue);
      write_csr(CSR_GREEN_AMOUNT, green);
      write_csr(CSR_RED_AMOUNT, red);
      csr_valid <= 1'b0;
   endtask

   initial begin
      plb_req_type          edge_pixels[3];
      logic [MODE_WIDTH-1:0] mode;

      // field order: top blue, green, red, then bottom blue, green, red
      edge_pixels[0] = {8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255};
      edge_pixels[1] = {8'd0, 8'd128, 8'd127, 8'd0, 8'd127, 8'd128};
      edge_pixels[2] = {8'd200, 8'd1, 8'd254, 8'd100, 8'd254, 8'd1};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every mode code over edge pixels, multiply on reset values
      for (int m = 0; m < 8; m++) begin
         if (m != 0)
            apply_settings(MODE_WIDTH'(m), (m % 2) ? '1 : '0, 8'd0, 8'd1, 8'd255);
         foreach (edge_pixels[i])
            send_pixel(edge_pixels[i], 1'b1);
      end

      // random phases, each with its own settings
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mode = MODE_WIDTH'((phase < 8) ? phase : $urandom_range(7));
         if (phase == 4)
            apply_settings(mode, JUNK_WIDTH'($urandom_range(31)), 8'd255, 8'd0, 8'd128);
         else if (phase == 5)
            apply_settings(mode, JUNK_WIDTH'($urandom_range(31)), 8'd0, 8'd255, 8'd2);
         else
            apply_settings(mode, JUNK_WIDTH'($urandom_range(31)), random_amount(),
                           random_amount(), random_amount());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold off mid-phase until every pending pixel is back
            if (phase == 3 && i == PHASE_ITEMS / 2)
               wait_idle();
            // phase six streams back to back
            send_pixel(random_pixel(), phase != 6);
         end
      end

      wait_idle();
      if (board.mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/plb_pkg.sv
hdl/plb_channel.sv
hdl/pixel_layer_blend.sv
tb/sv/tb_pixel_layer_blend.sv
